[sv/assert_macros.svh]
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SSSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SSSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/sssp_pkg.sv]
// Shared widths, codes and reset values for the shortest-path block
package sssp_pkg;

   // Fixed field widths
   localparam int VERTEX_W = 7;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 32;

   // Operation codes on the request word
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_RUN   = 1'b1;

   // Reset value of the vertex count register
   localparam logic [VERTEX_W-1:0] VC_RESET = 7'd64;

endpackage

[sv/sssp_ifs.sv]
// Valid/ready channel interfaces: request, response and register write
interface sssp_req_if;
   import sssp_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       op;
   logic        [VERTEX_W-1:0] from_vertex;
   logic        [VERTEX_W-1:0] to_vertex;
   logic signed [WEIGHT_W-1:0] weight;
   logic                       no_edge;
   logic        [VERTEX_W-1:0] src_vertex;

   modport source (output valid, op, from_vertex, to_vertex, weight, no_edge, src_vertex,
                   input ready);
   modport sink   (input valid, op, from_vertex, to_vertex, weight, no_edge, src_vertex,
                   output ready);
endinterface

interface sssp_rsp_if;
   import sssp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic      [VERTEX_W-1:0] vertex;
   logic signed [DIST_W-1:0] distance;
   logic                     reachable;
   logic      [VERTEX_W-1:0] predecessor;
   logic                     last;

   modport source (output valid, vertex, distance, reachable, predecessor, last,
                   input ready);
   modport sink   (input valid, vertex, distance, reachable, predecessor, last,
                   output ready);
endinterface

interface sssp_csr_if;
   import sssp_pkg::*;

   logic                valid;
   logic                ready;
   logic [VERTEX_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[sv/sssp_ram.sv]
// Generic single-write, single-read RAM with registered read data
module sssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

[sv/single_source_shortest_paths.sv]
// Bellman-Ford shortest paths over a dense weight store, one shared relax unit
//
//   channel  dir  handshake        word
//   req_ch   in   valid/ready      op, from_vertex, to_vertex, weight, no_edge, src_vertex
//   rsp_ch   out  valid/ready      vertex, distance, reachable, predecessor, last
//   csr_ch   in   valid/ready      vertex_count (always ready)
//
// A run with n vertices in use relaxes with one add/compare per cycle
// through the single read port of the weight and distance stores, then
// loads each result in S_ORD and S_OLD and holds it in S_OWAIT until
// rsp_ch takes it. Reset clears control state only; store contents are
// undefined until written. req_ch is not ready during a run.
module single_source_shortest_paths #(
   parameter int MAX_VERTICES = 64
) (
   input logic       clock,
   input logic       reset,
   sssp_req_if.sink  req_ch,
   sssp_rsp_if.source rsp_ch,
   sssp_csr_if.sink  csr_ch
);
   import sssp_pkg::*;

   `include "assert_macros.svh"

   localparam int IDX_W   = $clog2(MAX_VERTICES);
   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int NV_W    = IDX_W + 1;
   localparam int WADDR_W = 2 * IDX_W;
   localparam int WDEPTH  = 1 << WADDR_W;
   localparam int WWORD_W = WEIGHT_W + 1;
   localparam int DWORD_W = DIST_W + 1;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_INIT   = 10'b00_0000_0010,
      S_IDRAIN = 10'b00_0000_0100,
      S_VLOAD  = 10'b00_0000_1000,
      S_VGET   = 10'b00_0001_0000,
      S_RELAX  = 10'b00_0010_0000,
      S_RDRAIN = 10'b00_0100_0000,
      S_ORD    = 10'b00_1000_0000,
      S_OLD    = 10'b01_0000_0000,
      S_OWAIT  = 10'b10_0000_0000
   } state_type;

   // control registers
   state_type           state_ff, state_in;
   logic [VERTEX_W-1:0] vc_ff, vc_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [IDX_W-1:0]    s_ff, s_in;
   logic [IDX_W-1:0]    v_ff, v_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    pass_ff, pass_in;
   logic                p_valid_ff, p_valid_in;

   // datapath registers
   logic [IDX_W-1:0]         p_idx_ff, p_idx_in;
   logic                     cur_inf_ff, cur_inf_in;
   logic signed [DIST_W-1:0] cur_val_ff, cur_val_in;
   logic [IDX_W-1:0]         cur_pred_ff, cur_pred_in;

   // response word registers
   logic [VERTEX_W-1:0]      rsp_vertex_ff, rsp_vertex_in;
   logic signed [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic                     rsp_reach_ff, rsp_reach_in;
   logic [VERTEX_W-1:0]      rsp_pred_ff, rsp_pred_in;
   logic                     rsp_last_ff, rsp_last_in;

   // store ports
   logic                wt_we;
   logic [WADDR_W-1:0]  wt_waddr, wt_raddr;
   logic [WWORD_W-1:0]  wt_wdata, wt_rd;
   logic                dist_we;
   logic [IDX_W-1:0]    dist_waddr, dist_raddr;
   logic [DWORD_W-1:0]  dist_wdata, dist_rd;
   logic                pred_we;
   logic [IDX_W-1:0]    pred_wdata, pred_rd;

   logic                     req_acc, rsp_acc;
   logic [CNT_W-1:0]         n_eff;
   logic                     wr_ok, src_ok;
   logic [VERTEX_W-1:0]      src_m1;
   logic [IDX_W-1:0]         first_v;
   logic [NV_W-1:0]          vn1, v_next;
   logic                     v_end, cnt_last, pass_last;
   logic                     op_inf, cand_inf, relax_eval, improve;
   logic signed [DIST_W-1:0] op_val, cand_val, w_val;
   logic signed [DIST_W:0]   sum;
   logic                     init_inf;
   logic signed [DIST_W-1:0] init_val;

   sssp_ram #(.WIDTH(WWORD_W), .DEPTH(WDEPTH)) u_wt_ram (
      .clock   (clock),
      .wr_en   (wt_we),
      .wr_addr (wt_waddr),
      .wr_data (wt_wdata),
      .rd_addr (wt_raddr),
      .rd_data (wt_rd)
   );

   sssp_ram #(.WIDTH(DWORD_W), .DEPTH(MAX_VERTICES)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_addr (dist_raddr),
      .rd_data (dist_rd)
   );

   sssp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_pred_ram (
      .clock   (clock),
      .wr_en   (pred_we),
      .wr_addr (dist_waddr),
      .wr_data (pred_wdata),
      .rd_addr (v_ff),
      .rd_data (pred_rd)
   );

   // handshakes
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = (state_ff == S_OWAIT);
   assign rsp_acc      = rsp_ch.valid && rsp_ch.ready;

   assign rsp_ch.vertex      = rsp_vertex_ff;
   assign rsp_ch.distance    = rsp_dist_ff;
   assign rsp_ch.reachable   = rsp_reach_ff;
   assign rsp_ch.predecessor = rsp_pred_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // vertex count clamped to the supported range
   always_comb begin
      if (vc_ff < VERTEX_W'(2)) begin
         n_eff = CNT_W'(2);
      end else if (vc_ff > VERTEX_W'(MAX_VERTICES)) begin
         n_eff = CNT_W'(MAX_VERTICES);
      end else begin
         n_eff = CNT_W'(vc_ff);
      end
   end

   // request checks
   assign wr_ok  = (req_ch.from_vertex != '0) && (req_ch.from_vertex <= VERTEX_W'(MAX_VERTICES))
                && (req_ch.to_vertex != '0) && (req_ch.to_vertex <= VERTEX_W'(MAX_VERTICES));
   assign src_ok = (req_ch.src_vertex != '0) && (req_ch.src_vertex <= VERTEX_W'(n_eff));
   assign src_m1 = req_ch.src_vertex - VERTEX_W'(1);

   // weight store: writes while idle, reads during init and relaxation
   assign wt_we    = req_acc && (req_ch.op == OP_WRITE) && wr_ok;
   assign wt_waddr = {IDX_W'(req_ch.from_vertex - VERTEX_W'(1)),
                      IDX_W'(req_ch.to_vertex - VERTEX_W'(1))};
   assign wt_wdata = {req_ch.no_edge, req_ch.weight};
   assign wt_raddr = (state_ff == S_INIT) ? {s_ff, cnt_ff} : {cnt_ff, v_ff};

   // vertex walk, skipping the source
   assign first_v   = (s_ff == '0) ? IDX_W'(1) : '0;
   assign vn1       = NV_W'(v_ff) + NV_W'(1);
   assign v_next    = (vn1 == NV_W'(s_ff)) ? vn1 + NV_W'(1) : vn1;
   assign v_end     = (v_next >= NV_W'(n_ff));
   assign cnt_last  = (CNT_W'(cnt_ff) == n_ff - CNT_W'(1));
   // n-2 passes: the last one has index n-3
   assign pass_last = (pass_ff + CNT_W'(3) == n_ff);

   // initial distance: source row, source itself at zero
   assign init_inf = (p_idx_ff == s_ff) ? 1'b0 : wt_rd[WEIGHT_W];
   assign init_val = (p_idx_ff == s_ff) ? '0
                   : DIST_W'(signed'(wt_rd[WEIGHT_W-1:0]));

   // relax unit: saturating add and signed compare
   assign op_inf   = (p_idx_ff == v_ff) ? cur_inf_ff : dist_rd[DIST_W];
   assign op_val   = (p_idx_ff == v_ff) ? cur_val_ff : signed'(dist_rd[DIST_W-1:0]);
   assign w_val    = DIST_W'(signed'(wt_rd[WEIGHT_W-1:0]));
   assign sum      = (DIST_W+1)'(op_val) + (DIST_W+1)'(w_val);
   assign cand_inf = op_inf || wt_rd[WEIGHT_W];
   always_comb begin
      if (sum[DIST_W] != sum[DIST_W-1]) begin
         cand_val = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
      end else begin
         cand_val = sum[DIST_W-1:0];
      end
   end
   assign relax_eval = p_valid_ff && ((state_ff == S_RELAX) || (state_ff == S_RDRAIN));
   assign improve    = relax_eval && !cand_inf && (cur_inf_ff || (cur_val_ff > cand_val));

   // current target distance and predecessor
   always_comb begin
      cur_inf_in  = cur_inf_ff;
      cur_val_in  = cur_val_ff;
      cur_pred_in = cur_pred_ff;
      if (state_ff == S_VGET) begin
         cur_inf_in  = dist_rd[DIST_W];
         cur_val_in  = signed'(dist_rd[DIST_W-1:0]);
         cur_pred_in = pred_rd;
      end else if (improve) begin
         cur_inf_in  = 1'b0;
         cur_val_in  = cand_val;
         cur_pred_in = p_idx_ff;
      end
   end

   // distance and predecessor store writes
   always_comb begin
      dist_we    = 1'b0;
      pred_we    = 1'b0;
      dist_waddr = p_idx_ff;
      dist_wdata = {init_inf, init_val};
      pred_wdata = s_ff;
      if (((state_ff == S_INIT) || (state_ff == S_IDRAIN)) && p_valid_ff) begin
         dist_we = 1'b1;
         pred_we = 1'b1;
      end else if (state_ff == S_RDRAIN) begin
         dist_we    = 1'b1;
         pred_we    = 1'b1;
         dist_waddr = v_ff;
         dist_wdata = {cur_inf_in, cur_val_in};
         pred_wdata = cur_pred_in;
      end
   end
   assign dist_raddr = (state_ff == S_RELAX) ? cnt_ff : v_ff;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      vc_in      = vc_ff;
      n_in       = n_ff;
      s_in       = s_ff;
      v_in       = v_ff;
      cnt_in     = cnt_ff;
      pass_in    = pass_ff;
      p_valid_in = (state_ff == S_INIT) || (state_ff == S_RELAX);
      p_idx_in   = cnt_ff;

      if (csr_ch.valid && csr_ch.ready) begin
         vc_in = csr_ch.data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_ch.op == OP_RUN) && src_ok) begin
               s_in     = IDX_W'(src_m1);
               n_in     = n_eff;
               cnt_in   = '0;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_last) begin
               state_in = S_IDRAIN;
            end
         end
         S_IDRAIN: begin
            v_in     = first_v;
            pass_in  = '0;
            state_in = (n_ff == CNT_W'(2)) ? S_ORD : S_VLOAD;
         end
         S_VLOAD: begin
            state_in = S_VGET;
         end
         S_VGET: begin
            cnt_in   = '0;
            state_in = S_RELAX;
         end
         S_RELAX: begin
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_last) begin
               state_in = S_RDRAIN;
            end
         end
         S_RDRAIN: begin
            state_in = S_VLOAD;
            if (v_end) begin
               v_in = first_v;
               if (pass_last) begin
                  state_in = S_ORD;
               end else begin
                  pass_in = pass_ff + CNT_W'(1);
               end
            end else begin
               v_in = v_next[IDX_W-1:0];
            end
         end
         S_ORD: begin
            state_in = S_OLD;
         end
         S_OLD: begin
            state_in = S_OWAIT;
         end
         S_OWAIT: begin
            if (rsp_acc) begin
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  v_in     = v_next[IDX_W-1:0];
                  state_in = S_ORD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response word load
   always_comb begin
      rsp_vertex_in = rsp_vertex_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_reach_in  = rsp_reach_ff;
      rsp_pred_in   = rsp_pred_ff;
      rsp_last_in   = rsp_last_ff;
      if (state_ff == S_OLD) begin
         rsp_vertex_in = VERTEX_W'(v_ff) + VERTEX_W'(1);
         rsp_dist_in   = dist_rd[DIST_W] ? '0 : signed'(dist_rd[DIST_W-1:0]);
         rsp_reach_in  = !dist_rd[DIST_W];
         rsp_pred_in   = VERTEX_W'(pred_rd) + VERTEX_W'(1);
         rsp_last_in   = v_end;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         vc_ff      <= VC_RESET;
         p_valid_ff <= 1'b0;
         rsp_last_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         vc_ff      <= vc_in;
         p_valid_ff <= p_valid_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      s_ff          <= s_in;
      v_ff          <= v_in;
      cnt_ff        <= cnt_in;
      pass_ff       <= pass_in;
      p_idx_ff      <= p_idx_in;
      cur_inf_ff    <= cur_inf_in;
      cur_val_ff    <= cur_val_in;
      cur_pred_ff   <= cur_pred_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_reach_ff  <= rsp_reach_in;
      rsp_pred_ff   <= rsp_pred_in;
   end

   // checks
   `SSSP_ASSERT_IMPL(a_relax_bound, clock, reset, state_ff == S_RELAX,
      CNT_W'(cnt_ff) < n_ff, "relax index beyond vertex count")
   `SSSP_ASSERT_NEXT(a_last_to_idle, clock, reset, rsp_acc && rsp_last_ff,
      state_ff == S_IDLE, "no return to idle after last word")
   `SSSP_ASSERT_IMPL(a_target_not_source, clock, reset, state_ff == S_VGET,
      v_ff != s_ff, "source vertex taken as relax target")
   `SSSP_ASSERT_IMPL(a_pipe_state, clock, reset, p_valid_ff,
      (state_ff == S_INIT) || (state_ff == S_IDRAIN)
         || (state_ff == S_RELAX) || (state_ff == S_RDRAIN),
      "read pipe busy outside init or relax")

endmodule
